>>> hw/rtl/ibft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ibft_pkg;

   // default table depth
   localparam int IBFT_MAX_FORCES = 16;

   // result field widths
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_INPUT_AREA  = 1'b0;
   localparam logic CSR_OUTPUT_AREA = 1'b1;
   localparam logic [7:0] INPUT_AREA_RESET  = 8'd0;
   localparam logic [7:0] OUTPUT_AREA_RESET = 8'd1;

   // item function codes
   localparam logic [1:0] FUNC_SET   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_APPLY = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // force value that removes an entry, highest byte offset a force may use
   localparam logic [7:0]  REMOVE_VALUE = 8'd2;
   localparam logic [31:0] OFFSET_MAX   = 32'h0000_FFFF;

   typedef struct packed {
      logic [7:0]  area;
      logic [15:0] byte_off;
      logic [2:0]  bit_pos;
      logic        level;
   } entry_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  area;
      logic [31:0] byte_index;
      logic [2:0]  bit_pos;
      logic [7:0]  force_value;
      logic [7:0]  data_byte;
   } item_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic compare;
      logic commit;
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/ibft_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ibft_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  area;
   logic [31:0] byte_index;
   logic [2:0]  bit_pos;
   logic [7:0]  force_value;
   logic [7:0]  data_byte;

   modport source (
      output valid, func, area, byte_index, bit_pos, force_value, data_byte,
      input  ready
   );
   modport sink (
      input  valid, func, area, byte_index, bit_pos, force_value, data_byte,
      output ready
   );
endinterface
`default_nettype wire

>>> hw/rtl/ibft_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ibft_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] data_out;
   logic [4:0] force_count;

   modport source (
      output valid, status, data_out, force_count,
      input  ready
   );
   modport sink (
      input  valid, status, data_out, force_count,
      output ready
   );
endinterface
`default_nettype wire

>>> hw/rtl/io_bit_force_table.sv
`timescale 1ns / 1ps
`default_nettype none
// io bit force table: keeps up to MAX_FORCES forced bits keyed by area code, byte offset and
// bit number. A set beat (func 0) adds, updates or, with force value 2, removes a force; a clear
// beat (func 1) empties the table; an apply beat (func 2) returns its image byte with every
// matching forced bit set or cleared. Every request beat yields exactly one response beat with
// status, forced byte and the entry count after the beat. Three steps per beat: idle takes it in,
// compare checks it against all live entries in parallel and registers the match vector, commit
// updates the table and loads the response register, waiting until that register is free. The
// next beat can be taken the cycle after commit while the result waits there for the sink. Area
// codes for the input and output images are set over the APB port (register 0 at byte 0, register
// 1 at byte 4); the user must set them only while the block is idle, which it does not enforce.
module io_bit_force_table import ibft_pkg::*; #(
   parameter int MAX_FORCES = IBFT_MAX_FORCES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ibft_req_if.sink                   req_chan,
   ibft_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // area codes from the register block
   logic [7:0] input_area;
   logic [7:0] output_area;

   // controller commands and request beat payload
   cmd_type    cmd;
   item_type   req_item;
   logic       req_ready;
   logic       rsp_valid;

   ibft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .input_area  (input_area),
      .output_area (output_area)
   );

   // sequencer: idle, compare, commit
   ibft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // pack the request beat for capture
   always_comb begin
      req_item.func        = req_chan.func;
      req_item.area        = req_chan.area;
      req_item.byte_index  = req_chan.byte_index;
      req_item.bit_pos     = req_chan.bit_pos;
      req_item.force_value = req_chan.force_value;
      req_item.data_byte   = req_chan.data_byte;
   end

   // force table, match logic and response register
   ibft_dp #(
      .MAX_FORCES (MAX_FORCES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .input_area  (input_area),
      .output_area (output_area),
      .status      (rsp_chan.status),
      .data_out    (rsp_chan.data_out),
      .force_count (rsp_chan.force_count)
   );

endmodule
`default_nettype wire

>>> hw/rtl/ibft_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module ibft_csr import ibft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [7:0]            input_area,
   output logic      [7:0]            output_area
);

   logic [7:0] input_area_ff;
   logic [7:0] output_area_ff;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   // registers sit on 4-byte boundaries
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         input_area_ff  <= INPUT_AREA_RESET;
         output_area_ff <= OUTPUT_AREA_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            CSR_INPUT_AREA:  input_area_ff  <= pwdata[7:0];
            CSR_OUTPUT_AREA: output_area_ff <= pwdata[7:0];
            default:         input_area_ff  <= input_area_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_INPUT_AREA:  prdata = {{(CSR_DATA_W-8){1'b0}}, input_area_ff};
         CSR_OUTPUT_AREA: prdata = {{(CSR_DATA_W-8){1'b0}}, output_area_ff};
         default:         prdata = '0;
      endcase
   end

   assign input_area  = input_area_ff;
   assign output_area = output_area_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ibft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ibft_ctrl import ibft_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) & req_valid;
      cmd.compare = (state_ff == ST_MATCH);
      cmd.commit  = (state_ff == ST_COMMIT) & slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_MATCH;
            end
            ST_MATCH: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (slot_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result only ever comes out of the commit step
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result appeared without a commit");

   // an accepted item always goes to the compare step next
   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MATCH))
      else $error("accepted item skipped the compare step");

endmodule
`default_nettype wire

>>> hw/rtl/ibft_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ibft_dp import ibft_pkg::*; #(
   parameter int MAX_FORCES = IBFT_MAX_FORCES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire item_type           req_item,
   input  wire logic [7:0]         input_area,
   input  wire logic [7:0]         output_area,
   output logic      [STATUS_W-1:0] status,
   output logic      [7:0]         data_out,
   output logic      [COUNT_W-1:0] force_count
);

   localparam int IdxW = (MAX_FORCES > 1) ? $clog2(MAX_FORCES) : 1;
   localparam int CntW = $clog2(MAX_FORCES + 1);

   item_type                item_ff;
   entry_type               entry_ff [MAX_FORCES];
   logic [MAX_FORCES-1:0]   match_ff;
   logic [MAX_FORCES-1:0]   match_in;
   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic [STATUS_W-1:0]     status_ff;
   logic [STATUS_W-1:0]     status_in;
   logic [7:0]              dout_ff;
   logic [7:0]              dout_in;
   logic [COUNT_W-1:0]      fcount_ff;

   logic [IdxW-1:0]         hit_idx;
   logic                    found;
   logic [IdxW-1:0]         last_idx;
   logic                    bad;
   logic                    is_full;
   logic                    wr_en;
   logic [IdxW-1:0]         wr_idx;
   entry_type               wr_data;
   entry_type               new_entry;
   logic [7:0]              set_mask;
   logic [7:0]              clr_mask;

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_item;
   end

   // compare the item against every live entry; apply items ignore the bit
   always_comb begin
      for (int k = 0; k < MAX_FORCES; k++) begin
         match_in[k] = (CntW'(k) < count_ff)
                     && (entry_ff[k].area == item_ff.area)
                     && ({16'h0000, entry_ff[k].byte_off} == item_ff.byte_index)
                     && ((item_ff.func == FUNC_APPLY)
                         || (entry_ff[k].bit_pos == item_ff.bit_pos));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) match_ff <= match_in;
   end

   // last matching entry wins
   always_comb begin
      hit_idx = '0;
      for (int k = 0; k < MAX_FORCES; k++) begin
         if (match_ff[k]) hit_idx = IdxW'(k);
      end
   end

   assign found    = |match_ff;
   assign last_idx = IdxW'(count_ff - CntW'(1));
   assign bad      = ((item_ff.area != input_area) && (item_ff.area != output_area))
                   || (item_ff.byte_index > OFFSET_MAX);
   assign is_full  = (count_ff >= CntW'(MAX_FORCES));

   always_comb begin
      new_entry.area     = item_ff.area;
      new_entry.byte_off = item_ff.byte_index[15:0];
      new_entry.bit_pos  = item_ff.bit_pos;
      new_entry.level    = (item_ff.force_value != 8'd0);
   end

   // forced bits of the byte, one mask per level
   always_comb begin
      set_mask = '0;
      clr_mask = '0;
      for (int k = 0; k < MAX_FORCES; k++) begin
         if (match_ff[k]) begin
            if (entry_ff[k].level) set_mask = set_mask | (8'd1 << entry_ff[k].bit_pos);
            else                   clr_mask = clr_mask | (8'd1 << entry_ff[k].bit_pos);
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      dout_in   = '0;
      wr_en     = 1'b0;
      wr_idx    = hit_idx;
      wr_data   = new_entry;
      unique case (item_ff.func)
         FUNC_SET: begin
            priority if (bad) begin
               status_in = STATUS_BAD;
            end else if (item_ff.force_value == REMOVE_VALUE) begin
               // fill the hole with the last entry
               if (found) begin
                  count_in = count_ff - CntW'(1);
                  wr_en    = 1'b1;
                  wr_data  = entry_ff[last_idx];
               end
            end else if (found) begin
               wr_en = 1'b1;
            end else if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = IdxW'(count_ff);
               count_in = count_ff + CntW'(1);
            end
         end
         FUNC_CLEAR: count_in = '0;
         FUNC_APPLY: dout_in  = (item_ff.data_byte & ~clr_mask) | set_mask;
         default:    count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) entry_ff[wr_idx] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         dout_ff   <= dout_in;
         fcount_ff <= COUNT_W'(count_in);
      end
   end

   assign status      = status_ff;
   assign data_out    = dout_ff;
   assign force_count = fcount_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_FORCES))
      else $error("entry count beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && item_ff.func == FUNC_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries in the table");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_in == STATUS_FULL) |=> $stable(count_ff))
      else $error("full table changed its count");

endmodule
`default_nettype wire

>>> tb/sv/ibft_force_checker.sv
`timescale 1ns / 1ps
module ibft_force_checker import ibft_pkg::*; #(
   parameter int MAX_FORCES = IBFT_MAX_FORCES
) (
   input  logic                  clock,
   input  logic                  reset,
   ibft_req_if                   req_mon,
   ibft_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [7:0]          data_out;
      logic [COUNT_W-1:0]  force_count;
   } result_type;

   // shadow of the force table and area registers
   entry_type  force_slots [MAX_FORCES];
   int         live_count;
   logic [7:0] in_area;
   logic [7:0] out_area;
   int         mismatches;
   result_type expected_results [$];

   initial begin
      live_count = 0;
      mismatches = 0;
      in_area    = INPUT_AREA_RESET;
      out_area   = OUTPUT_AREA_RESET;
      fail_count = 0;
      pending    = 0;
   end

   function automatic result_type force_table_step(item_type it);
      result_type r;
      int         hit;
      logic [7:0] img;
      r.status   = STATUS_OK;
      r.data_out = 8'd0;
      case (it.func)
         FUNC_SET: begin
            if ((it.area != in_area && it.area != out_area) || it.byte_index > OFFSET_MAX) begin
               r.status = STATUS_BAD;
            end else begin
               hit = live_count;
               // last match wins
               for (int k = 0; k < live_count; k++) begin
                  if (force_slots[k].area == it.area &&
                      force_slots[k].byte_off == it.byte_index[15:0] &&
                      force_slots[k].bit_pos == it.bit_pos)
                     hit = k;
               end
               if (it.force_value == REMOVE_VALUE) begin
                  if (hit < live_count) begin
                     live_count--;
                     force_slots[hit] = force_slots[live_count];
                  end
               end else if (hit == live_count && live_count >= MAX_FORCES) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (hit == live_count)
                     live_count++;
                  force_slots[hit] = '{area: it.area, byte_off: it.byte_index[15:0],
                                       bit_pos: it.bit_pos, level: (it.force_value != 8'd0)};
               end
            end
         end
         FUNC_CLEAR: begin
            live_count = 0;
         end
         FUNC_APPLY: begin
            img = it.data_byte;
            // full 32-bit offset compare, no range check
            for (int k = 0; k < live_count; k++) begin
               if (force_slots[k].area == it.area &&
                   {16'd0, force_slots[k].byte_off} == it.byte_index)
                  img[force_slots[k].bit_pos] = force_slots[k].level;
            end
            r.data_out = img;
         end
         default: begin
         end
      endcase
      r.force_count = live_count[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      item_type   seen;
      result_type want;
      if (reset) begin
         live_count = 0;
         in_area    = INPUT_AREA_RESET;
         out_area   = OUTPUT_AREA_RESET;
         expected_results.delete();
      end else begin
         // a response beat never belongs to the request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with no result expected");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  mismatches++;
               end
               if (rsp_mon.data_out !== want.data_out) begin
                  $error("data_out: expected 0x%02h, got 0x%02h", want.data_out,
                         rsp_mon.data_out);
                  mismatches++;
               end
               if (rsp_mon.force_count !== want.force_count) begin
                  $error("force_count: expected %0d, got %0d", want.force_count,
                         rsp_mon.force_count);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seen.func        = req_mon.func;
            seen.area        = req_mon.area;
            seen.byte_index  = req_mon.byte_index;
            seen.bit_pos     = req_mon.bit_pos;
            seen.force_value = req_mon.force_value;
            seen.data_byte   = req_mon.data_byte;
            expected_results.push_back(force_table_step(seen));
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1] == CSR_INPUT_AREA)
               in_area = pwdata[7:0];
            else
               out_area = pwdata[7:0];
         end
      end
      fail_count <= mismatches;
      pending    <= expected_results.size();
   end

endmodule

>>> tb/sv/tb_io_bit_force_table.sv
`timescale 1ns / 1ps
// top of the force table bench: drives request beats and csr writes, lets the checker
// predict and compare, and reports the verdict
module tb_io_bit_force_table;
   import ibft_pkg::*;

   // codes and addresses used by the stimulus
   localparam logic [1:0]            FUNC_UNUSED      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_INPUT_AREA  = {CSR_INPUT_AREA, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_OUTPUT_AREA = {CSR_OUTPUT_AREA, 2'b00};
   localparam int PHASES          = 6;
   localparam int BEATS_PER_PHASE = 300;
   // quiet-cycle limit of the watchdog, well above any gap between beats or config pause
   localparam int WATCHDOG_LIMIT  = 2000;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int quiet_cycles = 0;

   // stimulus state: area codes in force, offsets that keys are drawn from, idle-free stretches
   logic [7:0]  in_code;
   logic [7:0]  out_code;
   logic [15:0] offset_pool [4];
   int          send_burst = 0;
   int          recv_burst = 0;

   ibft_req_if req_bus ();
   ibft_rsp_if rsp_bus ();

   io_bit_force_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   ibft_force_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: too long without any beat on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic item_type make_item(logic [1:0] func, logic [7:0] area,
                                          logic [31:0] byte_index, logic [2:0] bit_pos,
                                          logic [7:0] force_value, logic [7:0] data_byte);
      item_type it;
      it.func        = func;
      it.area        = area;
      it.byte_index  = byte_index;
      it.bit_pos     = bit_pos;
      it.force_value = force_value;
      it.data_byte   = data_byte;
      return it;
   endfunction

   // mostly well-formed traffic on a small key space so entries hit, update, fill and drain
   function automatic item_type random_item();
      item_type it;
      int       pick;
      it = make_item(FUNC_SET, $urandom_range(0, 1) ? in_code : out_code,
                     {16'd0, offset_pool[$urandom_range(0, 3)]}, 3'($urandom_range(0, 7)),
                     8'd0, 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
         0: it.force_value = REMOVE_VALUE;
         1: it.force_value = 8'd0;
         2: it.force_value = 8'd1;
         default: it.force_value = 8'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 47) begin
         it.func = FUNC_SET;
      end else if (pick < 84) begin
         it.func = FUNC_APPLY;
      end else if (pick < 85) begin
         it.func = FUNC_CLEAR;
      end else if (pick < 87) begin
         it.func = FUNC_UNUSED;
      end else begin
         // noise: any area, any 32-bit offset, any function
         it.func        = 2'($urandom_range(0, 3));
         it.area        = 8'($urandom_range(0, 255));
         it.byte_index  = $urandom();
         it.force_value = 8'($urandom_range(0, 255));
      end
      return it;
   endfunction

   // one csr write: setup, then access until pready, then idle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {{(CSR_DATA_W - 8){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_area_codes(input logic [7:0] in_value, input logic [7:0] out_value);
      in_code  = in_value;
      out_code = out_value;
      csr_write(ADDR_INPUT_AREA, in_value);
      csr_write(ADDR_OUTPUT_AREA, out_value);
   endtask

   // send one request beat after a random gap; valid stays high if the next beat follows at once
   task automatic send_beat(input item_type it);
      int gap;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 15) == 0)
            send_burst = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= it.func;
      req_bus.area        <= it.area;
      req_bus.byte_index  <= it.byte_index;
      req_bus.bit_pos     <= it.bit_pos;
      req_bus.force_value <= it.force_value;
      req_bus.data_byte   <= it.data_byte;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // stop sending and wait until every expected result has come, then let the block settle
   task automatic wait_table_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // response side: random stall per beat, with stall-free stretches
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (recv_burst > 0) begin
            stall = 0;
            recv_burst--;
         end else begin
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
               recv_burst = $urandom_range(8, 40);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // main stimulus
   initial begin
      logic [7:0] fill_levels [4];
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_SET;
      req_bus.area        = 8'd0;
      req_bus.byte_index  = 32'd0;
      req_bus.bit_pos     = 3'd0;
      req_bus.force_value = 8'd0;
      req_bus.data_byte   = 8'd0;
      in_code             = INPUT_AREA_RESET;
      out_code            = OUTPUT_AREA_RESET;
      fill_levels         = '{8'h00, 8'h01, 8'hFF, 8'h80};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with area codes at both extremes
      set_area_codes(8'h00, 8'hFF);
      // fill all sixteen slots: both areas, every bit, offsets 0 and 65535, low and high levels
      for (int k = 0; k < IBFT_MAX_FORCES; k++) begin
         send_beat(make_item(FUNC_SET, k[3] ? out_code : in_code,
                             k[0] ? 32'h0000_FFFF : 32'd0, k[2:0], fill_levels[k[1:0]],
                             8'h00));
      end
      // new key on a full table
      send_beat(make_item(FUNC_SET, in_code, 32'd1, 3'd0, 8'd1, 8'h00));
      // apply on both areas, and an apply beyond the force offset range that matches nothing
      send_beat(make_item(FUNC_APPLY, in_code, 32'd0, 3'd0, 8'd0, 8'hA5));
      send_beat(make_item(FUNC_APPLY, out_code, 32'h0000_FFFF, 3'd7, 8'd0, 8'h00));
      send_beat(make_item(FUNC_APPLY, out_code, 32'h0001_FFFF, 3'd0, 8'd0, 8'hFF));
      // update in place, remove with no match, remove a live entry
      send_beat(make_item(FUNC_SET, in_code, 32'd0, 3'd0, 8'd1, 8'h00));
      send_beat(make_item(FUNC_SET, in_code, 32'd500, 3'd3, REMOVE_VALUE, 8'h00));
      send_beat(make_item(FUNC_SET, in_code, 32'h0000_FFFF, 3'd5, REMOVE_VALUE, 8'h00));
      // bad area, offsets just and far past the limit
      send_beat(make_item(FUNC_SET, 8'h7F, 32'd0, 3'd1, 8'd1, 8'h00));
      send_beat(make_item(FUNC_SET, in_code, 32'h0001_0000, 3'd1, 8'd1, 8'h00));
      send_beat(make_item(FUNC_SET, out_code, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'hFF));
      // unused function code, then clear all
      send_beat(make_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'hFF));
      send_beat(make_item(FUNC_CLEAR, 8'd0, 32'd0, 3'd0, 8'd0, 8'h00));
      wait_table_idle();

      // random phases, each under its own area codes (reset values, extremes, equal codes, random codes)
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_area_codes(INPUT_AREA_RESET, OUTPUT_AREA_RESET);
            1: set_area_codes(8'hFF, 8'h00);
            2: set_area_codes(8'h5A, 8'h5A);
            3: set_area_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            4: set_area_codes(8'h00, 8'hFF);
            default: set_area_codes(8'hC3, 8'h3C);
         endcase
         offset_pool[0] = 16'h0000;
         offset_pool[1] = 16'hFFFF;
         offset_pool[2] = 16'($urandom_range(0, 16'hFFFF));
         offset_pool[3] = 16'($urandom_range(0, 16'hFFFF));
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // now and then let the response side catch up completely
            if ($urandom_range(0, 63) == 0)
               wait_table_idle();
            send_beat(random_item());
         end
         wait_table_idle();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> io_bit_force_table.f
hw/rtl/ibft_pkg.sv
hw/rtl/ibft_req_if.sv
hw/rtl/ibft_rsp_if.sv
hw/rtl/ibft_csr.sv
hw/rtl/ibft_ctrl.sv
hw/rtl/ibft_dp.sv
hw/rtl/io_bit_force_table.sv
tb/sv/ibft_force_checker.sv
tb/sv/tb_io_bit_force_table.sv
